/* src/umul_pkg.sv */
// Shared widths for the 256-bit low-half multiplier.
`timescale 1ns / 1ps
package umul_pkg;
    localparam int LIMB_W = 32;
    localparam int LIMBS  = 8;
    localparam int WORD_W = 64;
    localparam int OPND_W = LIMB_W * LIMBS;

    typedef logic [OPND_W-1:0] opnd_t;
    typedef logic [WORD_W-1:0] word_t;
    typedef logic [LIMB_W-1:0] limb_t;
endpackage

/* src/uint256_multiply_low.sv */
// Top level: 256 x 256 multiplier keeping the low 256 bits, as a row of cells.
// Pipeline: 8 cells of two stages each plus the output register, with the first
// stage loaded at the accepting edge. Throughput: one transaction per cycle while
// out_stall is low; each cell holds two transactions.
// Reset clears all valid bits asynchronously; payload registers are not reset.
`timescale 1ns / 1ps
module uint256_multiply_low (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  umul_pkg::word_t a_word0,
    input  umul_pkg::word_t a_word1,
    input  umul_pkg::word_t a_word2,
    input  umul_pkg::word_t a_word3,
    input  umul_pkg::word_t b_word0,
    input  umul_pkg::word_t b_word1,
    input  umul_pkg::word_t b_word2,
    input  umul_pkg::word_t b_word3,
    output logic            out_valid,
    input  logic            out_stall,
    output umul_pkg::word_t prod_word0,
    output umul_pkg::word_t prod_word1,
    output umul_pkg::word_t prod_word2,
    output umul_pkg::word_t prod_word3
);
    import umul_pkg::*;

    logic  valid_c [LIMBS+1];
    logic  ready_c [LIMBS+1];
    opnd_t a_c [LIMBS+1];
    opnd_t b_c [LIMBS+1];
    opnd_t acc_c [LIMBS+1];
    logic  out_valid_reg;
    opnd_t prod_reg;
    logic  out_ready;

    // Feed the row
    assign valid_c[0] = in_valid;
    assign a_c[0]     = {a_word3, a_word2, a_word1, a_word0};
    assign b_c[0]     = {b_word3, b_word2, b_word1, b_word0};
    assign acc_c[0]   = '0;
    assign in_stall   = !ready_c[0];

    for (genvar k = 0; k < LIMBS; k++)
    begin : g_cell
        umul_cell #(.CELL_IDX(k)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (valid_c[k]),
            .in_ready  (ready_c[k]),
            .in_a      (a_c[k]),
            .in_b      (b_c[k]),
            .in_acc    (acc_c[k]),
            .out_valid (valid_c[k+1]),
            .out_ready (ready_c[k+1]),
            .out_a     (a_c[k+1]),
            .out_b     (b_c[k+1]),
            .out_acc   (acc_c[k+1])
        );
    end

    // Output register parts the row from the consumer
    assign out_ready       = !out_valid_reg || !out_stall;
    assign ready_c[LIMBS]  = out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_ready)
            out_valid_reg <= valid_c[LIMBS];
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && valid_c[LIMBS])
            prod_reg <= acc_c[LIMBS];
    end

    assign out_valid  = out_valid_reg;
    assign prod_word0 = prod_reg[0*WORD_W +: WORD_W];
    assign prod_word1 = prod_reg[1*WORD_W +: WORD_W];
    assign prod_word2 = prod_reg[2*WORD_W +: WORD_W];
    assign prod_word3 = prod_reg[3*WORD_W +: WORD_W];

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        valid_c[LIMBS] && out_ready |=> out_valid_reg)
        else $error("last cell transaction dropped");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |=> out_valid_reg && $stable(prod_reg))
        else $error("stalled result changed");
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> valid_c[1] && out_valid_reg)
        else $error("input stalled with room in the row");
endmodule

/* src/umul_cell.sv */
// One schoolbook row: adds limb CELL_IDX of a times b into the running product.
`timescale 1ns / 1ps
module umul_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  umul_pkg::opnd_t in_a,
    input  umul_pkg::opnd_t in_b,
    input  umul_pkg::opnd_t in_acc,
    output logic           out_valid,
    input  logic           out_ready,
    output umul_pkg::opnd_t out_a,
    output umul_pkg::opnd_t out_b,
    output umul_pkg::opnd_t out_acc
);
    import umul_pkg::*;

    logic  s1_valid_reg;
    opnd_t s1_a_reg;
    opnd_t s1_b_reg;
    opnd_t s1_acc_reg;
    word_t s1_prod_reg [LIMBS];
    word_t prod_next [LIMBS];
    logic  s2_valid_reg;
    opnd_t s2_a_reg;
    opnd_t s2_b_reg;
    opnd_t s2_acc_reg;
    opnd_t acc_next;
    opnd_t even_sum;
    opnd_t odd_sum;
    logic  s1_ready;
    logic  s2_ready;

    // Advance a stage when it is empty or its successor takes its transaction
    assign s2_ready = !s2_valid_reg || out_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    // Form partial products whose low limb lands within the low 256 bits
    always_comb
    begin
        for (int j = 0; j < LIMBS; j++)
        begin
            if (j < LIMBS - CELL_IDX)
                prod_next[j] = WORD_W'(in_a[CELL_IDX*LIMB_W +: LIMB_W])
                             * WORD_W'(in_b[j*LIMB_W +: LIMB_W]);
            else
                prod_next[j] = '0;
        end
    end

    // Place even and odd products; products within each set do not overlap
    always_comb
    begin
        logic [2*OPND_W-1:0] ev;
        logic [2*OPND_W-1:0] od;
        ev = '0;
        od = '0;
        for (int j = 0; j < LIMBS; j++)
        begin
            if (j % 2 == 0)
                ev = ev | ((2*OPND_W)'(s1_prod_reg[j]) << (LIMB_W * (CELL_IDX + j)));
            else
                od = od | ((2*OPND_W)'(s1_prod_reg[j]) << (LIMB_W * (CELL_IDX + j)));
        end
        even_sum = ev[OPND_W-1:0];
        odd_sum  = od[OPND_W-1:0];
        acc_next = s1_acc_reg + even_sum + odd_sum;
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
                s1_valid_reg <= in_valid;
            if (s2_ready)
                s2_valid_reg <= s1_valid_reg;
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
        begin
            s1_a_reg   <= in_a;
            s1_b_reg   <= in_b;
            s1_acc_reg <= in_acc;
            for (int j = 0; j < LIMBS; j++)
                s1_prod_reg[j] <= prod_next[j];
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_a_reg   <= s1_a_reg;
            s2_b_reg   <= s1_b_reg;
            s2_acc_reg <= acc_next;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_a     = s2_a_reg;
    assign out_b     = s2_b_reg;
    assign out_acc   = s2_acc_reg;

    a_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> s1_valid_reg)
        else $error("accepted transaction not captured");
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s2_ready |=> s1_valid_reg && $stable(s1_acc_reg))
        else $error("blocked first stage lost its transaction");
    a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && !out_ready |=> s2_valid_reg && $stable(s2_acc_reg))
        else $error("blocked second stage lost its transaction");
endmodule
